FILE: hdl/srfr_pkg.sv
// ----------------------------------------------------------------------------
// srfr_pkg
// Types and constants shared by the servo reply frame receiver.
// ----------------------------------------------------------------------------
package srfr_pkg;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 9;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_GOOD     = 2'd1,
        ST_MISMATCH = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               first_flag;
        logic               last_flag;
        frame_status_t      frame_status;
    } frame_result_t;

endpackage

FILE: hdl/srfr_if.sv
// ----------------------------------------------------------------------------
// srfr_if
// Valid/ready channels of the servo reply frame receiver.
// ----------------------------------------------------------------------------

interface srfr_byte_if
    import srfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfr_frame_if
    import srfr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  frame_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               first_flag;
    logic               last_flag;
    logic [1:0]         frame_status;

    modport source (output valid, output frame_byte, output byte_index,
                    output first_flag, output last_flag, output frame_status,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input first_flag, input last_flag, input frame_status,
                    output ready);
endinterface

interface srfr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/srfr_in_stage.sv
// ----------------------------------------------------------------------------
// srfr_in_stage
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module srfr_in_stage
    import srfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              in_ready,
    output logic              stage_valid,
    output logic [BYTE_W-1:0] stage_byte,
    input  logic              stage_take
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready    = !valid_reg || stage_take;
    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

FILE: hdl/srfr_deframer.sv
// ----------------------------------------------------------------------------
// srfr_deframer
// Frame tracking, checksum and result register.
// ----------------------------------------------------------------------------
module srfr_deframer
    import srfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              check_enable,
    input  logic              stage_valid,
    input  logic [BYTE_W-1:0] stage_byte,
    output logic              stage_take,
    output logic              res_valid,
    output frame_result_t     res,
    input  logic              res_ready
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [INDEX_W-1:0] remaining_reg;
    logic [INDEX_W-1:0] remaining_next;
    logic [BYTE_W-1:0]  sum_reg;
    logic [BYTE_W-1:0]  sum_next;
    logic [INDEX_W-1:0] position_reg;
    logic [INDEX_W-1:0] position_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    frame_result_t      out_reg;
    frame_result_t      out_next;

    logic              emit;
    logic              end_of_frame;
    logic [BYTE_W-1:0] inv_byte;

    assign stage_take   = stage_valid && (!out_valid_reg || res_ready);
    assign inv_byte     = (~stage_byte) & BYTE_MASK;
    assign end_of_frame = (remaining_reg <= INDEX_W'(1));
    assign res_valid    = out_valid_reg;
    assign res          = out_reg;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (stage_take)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    if (end_of_frame)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = (stage_byte == START_BYTE) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    // Counters, checksum and the result item.
    always_comb
    begin
        remaining_next          = remaining_reg;
        sum_next                = sum_reg;
        position_next           = position_reg;
        emit                    = 1'b0;
        out_next.frame_byte     = stage_byte;
        out_next.byte_index     = position_reg;
        out_next.first_flag     = 1'b0;
        out_next.last_flag      = 1'b0;
        out_next.frame_status   = ST_PROGRESS;
        if (stage_take)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    emit           = 1'b1;
                    sum_next       = inv_byte;
                    remaining_next = {1'b0, stage_byte} + INDEX_W'(1);
                    position_next  = INDEX_W'(2);
                end
                PH_BODY:
                begin
                    emit = 1'b1;
                    if (end_of_frame)
                    begin
                        out_next.last_flag = 1'b1;
                        if (check_enable && (stage_byte != sum_reg))
                        begin
                            out_next.frame_status = ST_MISMATCH;
                        end
                        else
                        begin
                            out_next.frame_status = ST_GOOD;
                        end
                        remaining_next = '0;
                        sum_next       = '0;
                        position_next  = '0;
                    end
                    else
                    begin
                        sum_next       = sum_reg + inv_byte;
                        remaining_next = remaining_reg - INDEX_W'(1);
                        position_next  = position_reg + INDEX_W'(1);
                    end
                end
                default:
                begin
                    // Unused phase code falls back to hunting.
                    if (stage_byte == START_BYTE)
                    begin
                        emit                = 1'b1;
                        out_next.byte_index = '0;
                        out_next.first_flag = 1'b1;
                        remaining_next      = '0;
                        sum_next            = '0;
                        position_next       = INDEX_W'(1);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= '0;
            sum_reg       <= '0;
            position_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            position_reg  <= position_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    a_last_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last_flag == (out_reg.frame_status != ST_PROGRESS)))
        else $error("last flag and frame status disagree");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.first_flag && out_reg.last_flag))
        else $error("a frame byte is flagged both first and last");

    a_start_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_take && (phase_reg != PH_LEN) && (phase_reg != PH_BODY)
         && (stage_byte == START_BYTE)) |=> (phase_reg == PH_LEN))
        else $error("start byte did not open a frame");

    a_hunt_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> ((position_reg == '0) && (remaining_reg == '0)))
        else $error("counters not cleared while hunting");

endmodule

FILE: hdl/servo_reply_frame_receiver.sv
// ----------------------------------------------------------------------------
// servo_reply_frame_receiver
// Deframes servo reply frames out of a stream of received bus bytes.
// ----------------------------------------------------------------------------
// Bytes are taken on rx one per cycle unless frame stalls. Outside a frame
// every byte other than 0xAA is dropped; 0xAA opens a frame whose next byte
// is the length L, and the frame then runs for L+3 bytes in all. Each frame
// byte leaves on frame with its index and first/last flags; the last byte
// carries the status, good or checksum mismatch, where the checksum is the
// 8-bit sum of the inverted bytes from the length byte up to the byte before
// the checksum. The block sustains one byte per cycle: an input register
// feeds a single pass of frame-tracking logic into a result register, and a
// new byte is taken while a result still waits as long as that result is
// taken in the same cycle. A frame byte passes both registers in turn. The
// cfg channel writes check_enable (reset 1); with it clear, every complete
// frame is reported good. Write cfg only while the block is idle.
module servo_reply_frame_receiver
    import srfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    srfr_byte_if.sink    rx,
    srfr_frame_if.source frame,
    srfr_cfg_if.sink     cfg
);

    logic              check_enable_reg;
    logic              check_enable_next;
    logic              stage_valid;
    logic [BYTE_W-1:0] stage_byte;
    logic              stage_take;
    frame_result_t     res;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        check_enable_next = check_enable_reg;
        if (cfg.valid && cfg.ready)
        begin
            check_enable_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= 1'b1;
        end
        else
        begin
            check_enable_reg <= check_enable_next;
        end
    end

    srfr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rx.valid),
        .in_byte     (rx.rx_byte),
        .in_ready    (rx.ready),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte),
        .stage_take  (stage_take)
    );

    srfr_deframer u_deframer (
        .clk          (clk),
        .rst_n        (rst_n),
        .check_enable (check_enable_reg),
        .stage_valid  (stage_valid),
        .stage_byte   (stage_byte),
        .stage_take   (stage_take),
        .res_valid    (frame.valid),
        .res          (res),
        .res_ready    (frame.ready)
    );

    assign frame.frame_byte   = res.frame_byte;
    assign frame.byte_index   = res.byte_index;
    assign frame.first_flag   = res.first_flag;
    assign frame.last_flag    = res.last_flag;
    assign frame.frame_status = res.frame_status;

endmodule

FILE: verif/srfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfr_frame_checker
// Watches the byte, frame and cfg channels of the reply frame receiver,
// tracks the framing state on its own, and compares every frame transaction
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module srfr_frame_checker
    import srfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    srfr_byte_if  rx,
    srfr_frame_if frame,
    srfr_cfg_if   cfg,
    output int    fail_count,
    output int    pending
);

    localparam int MAX_PRINTED = 40;

    phase_t               trk_phase;
    logic [INDEX_W-1:0]   trk_left;
    logic [BYTE_W-1:0]    trk_sum;
    logic [INDEX_W-1:0]   trk_index;
    logic                 check_en;
    frame_result_t        expected_frames[$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTED)
        begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    // Advances the framing state by one received byte. Returns 1 when the
    // byte belongs to a frame and therefore leaves the block.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                        output frame_result_t r);
        r.frame_byte   = b;
        r.byte_index   = '0;
        r.first_flag   = 1'b0;
        r.last_flag    = 1'b0;
        r.frame_status = ST_PROGRESS;
        case (trk_phase)
            PH_LEN:
            begin
                r.byte_index = trk_index;
                trk_sum      = ~b;
                trk_left     = {1'b0, b} + 9'd1;
                trk_index    = 9'd2;
                trk_phase    = PH_BODY;
            end
            PH_BODY:
            begin
                r.byte_index = trk_index;
                if (trk_left <= 9'd1)
                begin
                    r.last_flag    = 1'b1;
                    r.frame_status = (check_en && b != trk_sum) ? ST_MISMATCH : ST_GOOD;
                    trk_phase      = PH_HUNT;
                    trk_left       = '0;
                    trk_sum        = '0;
                    trk_index      = '0;
                end
                else
                begin
                    trk_sum   = trk_sum + ~b;
                    trk_left  = trk_left - 9'd1;
                    trk_index = trk_index + 9'd1;
                end
            end
            default:
            begin
                // Hunting, and the unused phase code behaves the same way.
                trk_phase = PH_HUNT;
                if (b != START_BYTE)
                begin
                    return 1'b0;
                end
                r.first_flag = 1'b1;
                trk_phase    = PH_LEN;
                trk_sum      = '0;
                trk_left     = '0;
                trk_index    = 9'd1;
            end
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        frame_result_t next_byte;
        if (!rst_n)
        begin
            trk_phase = PH_HUNT;
            trk_left  = '0;
            trk_sum   = '0;
            trk_index = '0;
            check_en  = 1'b1;
            expected_frames.delete();
            pending = 0;
        end
        else
        begin
            // A frame transaction can never come from a byte taken at the
            // same edge, so it is matched before the new byte is predicted.
            if (frame.valid === 1'b1 && frame.ready === 1'b1)
            begin
                if (expected_frames.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected frame byte %02h index %0d",
                                              frame.frame_byte, frame.byte_index));
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (frame.frame_byte !== want.frame_byte)
                        report_mismatch($sformatf("frame_byte got %02h want %02h",
                                                  frame.frame_byte, want.frame_byte));
                    if (frame.byte_index !== want.byte_index)
                        report_mismatch($sformatf("byte_index got %0d want %0d",
                                                  frame.byte_index, want.byte_index));
                    if (frame.first_flag !== want.first_flag)
                        report_mismatch($sformatf("first_flag got %b want %b at index %0d",
                                                  frame.first_flag, want.first_flag,
                                                  want.byte_index));
                    if (frame.last_flag !== want.last_flag)
                        report_mismatch($sformatf("last_flag got %b want %b at index %0d",
                                                  frame.last_flag, want.last_flag,
                                                  want.byte_index));
                    if (frame.frame_status !== want.frame_status)
                        report_mismatch($sformatf("frame_status got %0d want %0d at index %0d",
                                                  frame.frame_status, want.frame_status,
                                                  want.byte_index));
                end
            end
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                check_en = cfg.data;
            end
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
            begin
                if (deframe_byte(rx.rx_byte, next_byte))
                begin
                    expected_frames.push_back(next_byte);
                end
            end
            pending = expected_frames.size();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes and checksum settings into the servo reply frame
// receiver under several idle and stall mixes, and reports the verdict of
// the frame checker.
// ----------------------------------------------------------------------------
module testbench
    import srfr_pkg::*;
;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 335;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_CUT
    } frame_kind_t;

    logic clk;
    logic rst_n;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_off_left;
    int frame_items;
    int fail_count;
    int pending;

    srfr_byte_if  rx_if ();
    srfr_frame_if frame_if ();
    srfr_cfg_if   cfg_if ();

    servo_reply_frame_receiver uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if),
        .cfg   (cfg_if)
    );

    srfr_frame_checker frame_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_if),
        .frame      (frame_if),
        .cfg        (cfg_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // Frame receiver side: random stalls, or a long hold-off when asked.
    initial
    begin
        frame_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                frame_if.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                frame_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (rx_if.ready !== 1'b1);
    endtask

    function automatic logic [BYTE_W-1:0] pick_payload();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0:       return START_BYTE;
            1:       return 8'h00;
            2:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 8'd0;
        else if (pick < 85)
            return BYTE_W'($urandom_range(6, 1));
        else
            return BYTE_W'($urandom_range(40, 7));
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] len, input frame_kind_t kind);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int body;
        body = (kind == FRAME_CUT) ? $urandom_range(len) : len;
        send_byte(START_BYTE);
        send_byte(len);
        sum = ~len;
        frame_items += 2;
        for (int i = 0; i < body; i++)
        begin
            b = pick_payload();
            send_byte(b);
            sum = sum + ~b;
            frame_items++;
        end
        // A cut frame leaves out its checksum, so whatever follows is
        // swallowed as the rest of the frame.
        if (kind != FRAME_CUT)
        begin
            if (kind == FRAME_BAD_SUM)
                sum = sum ^ (8'd1 << $urandom_range(7));
            send_byte(sum);
            frame_items++;
        end
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // Dropped bytes have no result to wait for, so let the pipeline empty.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_check_enable(input logic value);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int target, input bit long_frame,
                                    input frame_kind_t long_kind);
        int stop_at;
        int pick;
        stop_at = frame_items + target;
        if (long_frame)
            send_frame(8'hFF, long_kind);
        while (frame_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(pick_length(), FRAME_GOOD);
            else if (pick < 82)
                send_frame(pick_length(), FRAME_BAD_SUM);
            else if (pick < 92)
                repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
            else
                send_frame(pick_length(), FRAME_CUT);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_left  = 0;
        frame_items    = 0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, checksum checking at its reset setting.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        // Zero length, good and then bad checksum.
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'hFF);
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00);
        // A start byte inside the body is plain data.
        send_byte(START_BYTE); send_byte(8'h02); send_byte(START_BYTE);
        send_byte(8'h00); send_byte(8'h51);
        send_byte(START_BYTE); send_byte(8'h01); send_byte(8'hFF); send_byte(8'hFE);
        // A bad frame ending on a start byte must not open a new frame.
        send_byte(START_BYTE); send_byte(8'h00); send_byte(START_BYTE);
        send_byte(START_BYTE); send_byte(8'h00); send_byte(8'hFF);

        // No idling, with a long receiver hold-off that backs up the input.
        write_check_enable(1'b1);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_left  = HOLD_CYCLES;
        run_random_phase(PHASE_ITEMS, 1'b0, FRAME_GOOD);

        write_check_enable(1'b0);
        src_idle_pct   = 57;
        sink_stall_pct = 0;
        run_random_phase(PHASE_ITEMS, 1'b1, FRAME_BAD_SUM);

        write_check_enable(1'b1);
        src_idle_pct   = 0;
        sink_stall_pct = 57;
        run_random_phase(PHASE_ITEMS, 1'b1, FRAME_GOOD);

        write_check_enable(1'b0);
        src_idle_pct   = 27;
        sink_stall_pct = 27;
        run_random_phase(PHASE_ITEMS, 1'b0, FRAME_GOOD);

        wait_idle();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
